/* src/mqsb_pkg.sv */
// shared constants, types and helpers for the multi-queue shared buffer
package mqsb_pkg;

    localparam int SLOTS   = 16;
    localparam int QUEUES  = 4;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int LINK_W  = SLOT_W + 1;
    localparam int QSEL_W  = 2;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [LINK_W-1:0] t_link;
    typedef logic [QSEL_W-1:0] t_qsel;
    typedef logic [DATA_W-1:0] t_data;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_link   LINK_NONE    = LINK_W'(SLOTS);
    localparam logic    OP_ENQ       = 1'b0;
    localparam logic    OP_DEQ       = 1'b1;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_OVERFLOW  = 2'd1;
    localparam t_status ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic  link_we;
        logic  data_we;
        t_slot wr_addr;
        t_link wr_link;
        t_data wr_data;
        logic  rd_en;
        t_slot rd_addr;
    } t_store_req;

    function automatic logic is_slot(input t_link x);
        is_slot = (x < LINK_NONE);
    endfunction

endpackage

/* src/mqsb_in_if.sv */
// input channel: operation beat with valid/ready handshake
interface mqsb_in_if;
    logic                  valid;
    logic                  ready;
    logic                  op;
    mqsb_pkg::t_qsel       queue_sel;
    logic signed [31:0]    push_data;

    modport source (output valid, op, queue_sel, push_data, input ready);
    modport sink   (input valid, op, queue_sel, push_data, output ready);
endinterface

/* src/mqsb_out_if.sv */
// output channel: result beat with valid/ready handshake
interface mqsb_out_if;
    logic                  valid;
    logic                  ready;
    logic signed [31:0]    pop_data;
    mqsb_pkg::t_status     status;

    modport source (output valid, pop_data, status, input ready);
    modport sink   (input valid, pop_data, status, output ready);
endinterface

/* src/mqsb_store.sv */
// slot store: data and next-link arrays with registered read
module mqsb_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mqsb_pkg::t_store_req i_req,
    output mqsb_pkg::t_link      o_rd_link,
    output mqsb_pkg::t_data      o_rd_data
);

    mqsb_pkg::t_link r_link [mqsb_pkg::SLOTS];
    mqsb_pkg::t_data r_data [mqsb_pkg::SLOTS];
    mqsb_pkg::t_link r_rd_link;
    mqsb_pkg::t_data r_rd_data;

    // reset chains every slot into the free list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mqsb_pkg::SLOTS; i++) begin
                r_link[i] <= mqsb_pkg::LINK_W'(i + 1);
            end
        end else if (i_req.link_we) begin
            r_link[i_req.wr_addr] <= i_req.wr_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.data_we) begin
            r_data[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_link <= r_link[i_req.rd_addr];
            r_rd_data <= r_data[i_req.rd_addr];
        end
    end

    assign o_rd_link = r_rd_link;
    assign o_rd_data = r_rd_data;

endmodule

/* src/multi_queue_shared_buffer.sv */
// top level: several fifo queues sharing one linked slot store with a free list
//
// i_in carries one operation per beat: op (enqueue or dequeue), queue_sel and
// push_data. o_out returns exactly one beat per operation: pop_data and status
// (ok, overflow on enqueue with no free slot, underflow on empty dequeue).
// an operation is taken when valid and ready are both high; ready is high only
// while the sequencer is idle. each operation runs a read state (slot link and
// data read from the store; tail link, tail and empty-queue head written) and a
// write state (dequeued head, free-list head and slot updated, result loaded into
// the output register). the sequencer takes a new operation only after the
// write state returns it to idle, so operations never overlap.
// the output register holds its beat while the receiver stalls; a finished
// operation then waits in its write state until the register is free.
// reset chains all slots into the free list and empties all queues at once,
// with no clearing pass; the block is ready as soon as reset is released.
module multi_queue_shared_buffer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mqsb_in_if.sink    i_in,
    mqsb_out_if.source o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WRITE
    } t_state;

    t_state                r_state;
    logic                  r_op;
    mqsb_pkg::t_qsel       r_q;
    mqsb_pkg::t_data       r_push;
    logic                  r_err;
    mqsb_pkg::t_slot       r_slot;
    mqsb_pkg::t_link       r_free_head;
    mqsb_pkg::t_link       r_qhead [mqsb_pkg::QUEUES];
    mqsb_pkg::t_slot       r_qtail [mqsb_pkg::QUEUES];
    logic                  r_out_valid;
    mqsb_pkg::t_data       r_pop;
    mqsb_pkg::t_status     r_status;

    mqsb_pkg::t_store_req  s_req;
    mqsb_pkg::t_link       s_rd_link;
    mqsb_pkg::t_data       s_rd_data;
    logic                  s_q_ok;
    logic                  s_err;
    logic                  s_head_valid;
    logic                  s_advance;

    assign s_q_ok       = (int'(r_q) < mqsb_pkg::QUEUES);
    assign s_head_valid = mqsb_pkg::is_slot(r_qhead[r_q]);
    assign s_err        = (r_op == mqsb_pkg::OP_ENQ)
                        ? (!s_q_ok || !mqsb_pkg::is_slot(r_free_head))
                        : (!s_q_ok || !s_head_valid);
    assign s_advance    = (r_state == S_WRITE) && (!r_out_valid || o_out.ready);

    always_comb begin
        s_req = '0;
        case (r_state)
            S_READ: begin
                s_req.rd_en   = 1'b1;
                s_req.rd_addr = (r_op == mqsb_pkg::OP_ENQ)
                              ? r_free_head[mqsb_pkg::SLOT_W-1:0]
                              : r_qhead[r_q][mqsb_pkg::SLOT_W-1:0];
                // append the free slot behind the current tail
                if (!s_err && r_op == mqsb_pkg::OP_ENQ && s_head_valid) begin
                    s_req.link_we = 1'b1;
                    s_req.wr_addr = r_qtail[r_q];
                    s_req.wr_link = r_free_head;
                end
            end
            S_WRITE: begin
                if (s_advance && !r_err) begin
                    s_req.link_we = 1'b1;
                    s_req.wr_addr = r_slot;
                    if (r_op == mqsb_pkg::OP_ENQ) begin
                        s_req.data_we = 1'b1;
                        s_req.wr_data = r_push;
                        s_req.wr_link = mqsb_pkg::LINK_NONE;
                    end else begin
                        s_req.wr_link = r_free_head;
                    end
                end
            end
            default: begin
                s_req = '0;
            end
        endcase
    end

    mqsb_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (s_req),
        .o_rd_link (s_rd_link),
        .o_rd_data (s_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < mqsb_pkg::QUEUES; i++) begin
                r_qhead[i] <= mqsb_pkg::LINK_NONE;
            end
        end else begin
            if (r_out_valid && o_out.ready && !s_advance) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op    <= i_in.op;
                        r_q     <= i_in.queue_sel;
                        r_push  <= i_in.push_data;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_err  <= s_err;
                    r_slot <= s_req.rd_addr;
                    if (!s_err && r_op == mqsb_pkg::OP_ENQ && !s_head_valid) begin
                        r_qhead[r_q] <= {1'b0, r_free_head[mqsb_pkg::SLOT_W-1:0]};
                    end
                    if (!s_err && r_op == mqsb_pkg::OP_ENQ) begin
                        r_qtail[r_q] <= r_free_head[mqsb_pkg::SLOT_W-1:0];
                    end
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (s_advance) begin
                        r_out_valid <= 1'b1;
                        r_pop       <= '0;
                        if (r_err) begin
                            r_status <= (r_op == mqsb_pkg::OP_ENQ)
                                      ? mqsb_pkg::ST_OVERFLOW : mqsb_pkg::ST_UNDERFLOW;
                        end else begin
                            r_status <= mqsb_pkg::ST_OK;
                            if (r_op == mqsb_pkg::OP_ENQ) begin
                                r_free_head <= mqsb_pkg::is_slot(s_rd_link)
                                             ? s_rd_link : mqsb_pkg::LINK_NONE;
                            end else begin
                                r_qhead[r_q] <= mqsb_pkg::is_slot(s_rd_link)
                                              ? s_rd_link : mqsb_pkg::LINK_NONE;
                                r_free_head  <= {1'b0, r_slot};
                                r_pop        <= s_rd_data;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.pop_data = r_pop;
    assign o_out.status   = r_status;

endmodule

/* tb/testbench.sv */
// self-checking testbench for the multi-queue shared buffer with a free-list predictor
module testbench;

    typedef struct packed {
        mqsb_pkg::t_data   pop;
        mqsb_pkg::t_status status;
    } t_pop_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mqsb_in_if  op_ch();
    mqsb_out_if res_ch();

    multi_queue_shared_buffer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_ch),
        .o_out   (res_ch)
    );

    localparam int IDLE_LIMIT = 2000;

    // predictor state
    mqsb_pkg::t_data slot_data  [mqsb_pkg::SLOTS];
    mqsb_pkg::t_link slot_link  [mqsb_pkg::SLOTS];
    mqsb_pkg::t_link queue_head [mqsb_pkg::QUEUES];
    mqsb_pkg::t_slot queue_tail [mqsb_pkg::QUEUES];
    mqsb_pkg::t_link free_head;

    t_pop_result pending_pops[$];
    int          error_count;
    int          idle_cycles;
    int          send_burst;
    int          sink_burst;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_pop_result predict_buffer_op(input logic op,
                                                      input mqsb_pkg::t_qsel q,
                                                      input mqsb_pkg::t_data d);
        t_pop_result     r;
        mqsb_pkg::t_slot s;
        mqsb_pkg::t_link nxt;
        r.pop    = '0;
        r.status = mqsb_pkg::ST_OK;
        if (op == mqsb_pkg::OP_ENQ) begin
            if (int'(q) >= mqsb_pkg::QUEUES || free_head >= mqsb_pkg::LINK_NONE) begin
                r.status = mqsb_pkg::ST_OVERFLOW;
            end else begin
                s         = mqsb_pkg::t_slot'(free_head);
                free_head = (slot_link[s] < mqsb_pkg::LINK_NONE)
                          ? slot_link[s] : mqsb_pkg::LINK_NONE;
                if (queue_head[q] >= mqsb_pkg::LINK_NONE) begin
                    queue_head[q] = mqsb_pkg::t_link'(s);
                end else begin
                    slot_link[queue_tail[q]] = mqsb_pkg::t_link'(s);
                end
                slot_data[s]  = d;
                slot_link[s]  = mqsb_pkg::LINK_NONE;
                queue_tail[q] = s;
            end
        end else begin
            if (int'(q) >= mqsb_pkg::QUEUES || queue_head[q] >= mqsb_pkg::LINK_NONE) begin
                r.status = mqsb_pkg::ST_UNDERFLOW;
            end else begin
                s             = mqsb_pkg::t_slot'(queue_head[q]);
                nxt           = slot_link[s];
                queue_head[q] = (nxt < mqsb_pkg::LINK_NONE) ? nxt : mqsb_pkg::LINK_NONE;
                slot_link[s]  = free_head;
                free_head     = mqsb_pkg::t_link'(s);
                r.pop         = slot_data[s];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // mostly short gaps, a few long ones, and bursts with none
    task automatic next_gap(inout int burst_left, output int gap);
        int r;
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else if ($urandom_range(0, 19) == 0) begin
            burst_left = $urandom_range(10, 40);
        end else begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                gap = 0;
            end else if (r < 85) begin
                gap = $urandom_range(1, 3);
            end else if (r < 96) begin
                gap = $urandom_range(4, 12);
            end else begin
                gap = $urandom_range(20, 60);
            end
        end
    endtask

    task automatic send_op(input logic op, input mqsb_pkg::t_qsel q,
                           input mqsb_pkg::t_data d);
        int gap;
        next_gap(send_burst, gap);
        if (gap > 0) begin
            @(negedge i_clk);
            op_ch.valid     <= 1'b0;
            op_ch.op        <= 1'($urandom);
            op_ch.queue_sel <= mqsb_pkg::t_qsel'($urandom);
            op_ch.push_data <= $urandom;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        op_ch.valid     <= 1'b1;
        op_ch.op        <= op;
        op_ch.queue_sel <= q;
        op_ch.push_data <= d;
        do @(posedge i_clk); while (!op_ch.ready);
        pending_pops.push_back(predict_buffer_op(op, q, d));
    endtask

    task automatic test_empty_dequeue();
        for (int q = 0; q < mqsb_pkg::QUEUES; q++) begin
            send_op(mqsb_pkg::OP_DEQ, mqsb_pkg::t_qsel'(q), $urandom);
        end
    endtask

    task automatic test_fill_and_overflow();
        mqsb_pkg::t_data extremes [4];
        extremes = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff};
        for (int i = 0; i < mqsb_pkg::SLOTS; i++) begin
            send_op(mqsb_pkg::OP_ENQ, mqsb_pkg::t_qsel'(i % mqsb_pkg::QUEUES),
                    (i < 4) ? extremes[i] : mqsb_pkg::t_data'($urandom));
        end
        send_op(mqsb_pkg::OP_ENQ,
                mqsb_pkg::t_qsel'($urandom_range(0, mqsb_pkg::QUEUES - 1)), $urandom);
    endtask

    task automatic test_drain_heads();
        for (int q = 0; q < mqsb_pkg::QUEUES; q++) begin
            send_op(mqsb_pkg::OP_DEQ, mqsb_pkg::t_qsel'(q), $urandom);
        end
    endtask

    task automatic test_random_traffic(input int n_items);
        int              sent;
        int              run_len;
        int              enq_pct;
        int              focus;
        logic            op;
        mqsb_pkg::t_qsel q;
        mqsb_pkg::t_data d;
        sent = 0;
        while (sent < n_items) begin
            run_len = $urandom_range(16, 64);
            case ($urandom_range(0, 3))
                0: enq_pct = 15;
                1: enq_pct = 50;
                2: enq_pct = 85;
                default: enq_pct = 97;
            endcase
            focus = $urandom_range(0, 1)
                  ? int'($urandom_range(0, mqsb_pkg::QUEUES - 1)) : -1;
            repeat (run_len) begin
                op = ($urandom_range(0, 99) < enq_pct) ? mqsb_pkg::OP_ENQ : mqsb_pkg::OP_DEQ;
                q  = (focus >= 0) ? mqsb_pkg::t_qsel'(focus)
                                  : mqsb_pkg::t_qsel'($urandom_range(0, 3));
                case ($urandom_range(0, 11))
                    0: d = 32'h7fff_ffff;
                    1: d = 32'h8000_0000;
                    2: d = 32'h0000_0000;
                    3: d = 32'hffff_ffff;
                    default: d = $urandom;
                endcase
                send_op(op, q, d);
                sent++;
            end
        end
    endtask

    // result sink with random stalls
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        sink_burst   = 0;
        forever begin
            next_gap(sink_burst, stall);
            if (stall > 0) begin
                @(negedge i_clk);
                res_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    always @(posedge i_clk) begin
        t_pop_result want;
        if (res_ch.valid && res_ch.ready) begin
            if (pending_pops.size() == 0) begin
                report_mismatch("beat with nothing pending", res_ch.pop_data, '0);
            end else begin
                want = pending_pops.pop_front();
                if (res_ch.pop_data !== want.pop) begin
                    report_mismatch("pop_data", res_ch.pop_data, want.pop);
                end
                if (res_ch.status !== want.status) begin
                    report_mismatch("status", 32'(res_ch.status), 32'(want.status));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        send_burst      = 0;
        i_rst_n         = 1'b0;
        op_ch.valid     = 1'b0;
        op_ch.op        = mqsb_pkg::OP_ENQ;
        op_ch.queue_sel = '0;
        op_ch.push_data = '0;
        for (int i = 0; i < mqsb_pkg::SLOTS; i++) begin
            slot_data[i] = '0;
            slot_link[i] = mqsb_pkg::t_link'(i + 1);
        end
        slot_link[mqsb_pkg::SLOTS - 1] = mqsb_pkg::LINK_NONE;
        for (int q = 0; q < mqsb_pkg::QUEUES; q++) begin
            queue_head[q] = mqsb_pkg::LINK_NONE;
            queue_tail[q] = '0;
        end
        free_head = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_dequeue();
        test_fill_and_overflow();
        test_drain_heads();
        test_random_traffic(1025);

        @(negedge i_clk);
        op_ch.valid <= 1'b0;
        while (pending_pops.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
